@@ src/mbp_pkg.sv @@
package mbp_pkg;

  // Default ring size and the reset value of the pacing period.
  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam logic [7:0]  TX_PERIOD_RST  = 8'd16;

  // Configuration port geometry: one 32-bit register at byte address 0.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic        REG_TX_PERIOD = 1'b0;

  // Stream widths: the port word in, and the packed result fields out.
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 16;

  // What the ring control hands to the result stage for one word.
  typedef struct packed {
    logic       send;      // a byte leaves the ring in this frame
    logic       drop;      // the oldest byte was discarded
    logic       bypass;    // the sent byte is the one written in this frame
    logic [7:0] push_byte; // byte written in this frame
  } issue_t;

endpackage

@@ src/mbp_ram.sv @@
module mbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/mbp_cfg.sv @@
module mbp_cfg
  import mbp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [7:0]            tx_period
);

  logic wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Period register; writes to other word addresses are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_period <= TX_PERIOD_RST;
    end else if (wr_en && (paddr[2] == REG_TX_PERIOD)) begin
      tx_period <= pwdata[7:0];
    end
  end

  // Read back the period; other addresses read as zero.
  always_comb begin
    if (paddr[2] == REG_TX_PERIOD) begin
      prdata = {{(CFG_DATA_W-8){1'b0}}, tx_period};
    end else begin
      prdata = '0;
    end
  end

endmodule

@@ src/mbp_ctrl.sv @@
module mbp_ctrl
  import mbp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic [IN_DATA_W-1:0]          port_word,
  input  logic [7:0]                    tx_period,
  output logic                          ram_we,
  output logic [$clog2(RING_DEPTH)-1:0] ram_waddr,
  output logic [7:0]                    ram_wdata,
  output logic                          ram_re,
  output logic [$clog2(RING_DEPTH)-1:0] ram_raddr,
  output issue_t                        issue
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

  logic [PTR_W-1:0] write_ptr, write_ptr_next;
  logic [PTR_W-1:0] read_ptr, read_ptr_next;
  logic [7:0]       hold_count, hold_count_next;

  logic [7:0]       hold_dec;
  logic             push;
  logic [PTR_W-1:0] wp_inc, rp_inc, rp_after_drop, rp_after_inc;
  logic             drop, send;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] idx);
    ring_next = (idx == PTR_LAST) ? '0 : idx + 1'b1;
  endfunction

  // Count down, push with overwrite of the oldest byte, then send if paced.
  always_comb begin
    hold_dec       = (hold_count != 8'd0) ? hold_count - 8'd1 : hold_count;
    push           = (port_word[31:24] != 8'd0);
    wp_inc         = ring_next(write_ptr);
    write_ptr_next = push ? wp_inc : write_ptr;
    drop           = push && (wp_inc == read_ptr);
    rp_inc         = ring_next(read_ptr);
    rp_after_drop  = drop ? rp_inc : read_ptr;
    send           = (write_ptr_next != rp_after_drop) && (hold_dec == 8'd0);
    rp_after_inc   = ring_next(rp_after_drop);
    read_ptr_next  = send ? rp_after_inc : rp_after_drop;
    hold_count_next = send ? tx_period : hold_dec;
  end

  // Ring memory access for this word.
  assign ram_we    = accept && push;
  assign ram_waddr = write_ptr;
  assign ram_wdata = port_word[7:0];
  assign ram_re    = accept;
  assign ram_raddr = rp_after_drop;

  // The memory reads the old contents on a same-cycle hit, so flag it.
  assign issue.send      = send;
  assign issue.drop      = drop;
  assign issue.bypass    = push && (rp_after_drop == write_ptr);
  assign issue.push_byte = port_word[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      write_ptr  <= '0;
      read_ptr   <= '0;
      hold_count <= 8'd0;
    end else if (accept) begin
      write_ptr  <= write_ptr_next;
      read_ptr   <= read_ptr_next;
      hold_count <= hold_count_next;
    end
  end

endmodule

@@ src/midi_byte_pacer_fifo.sv @@
// MIDI byte pacer with a ring buffer that overwrites its oldest byte.
//
// Input stream (s_*): one 32-bit port word per audio frame. A word whose top
// byte is nonzero carries a MIDI byte in its low byte, which is buffered.
// Output stream (m_*): one result word per input word, carrying send_valid,
// the sent byte (zero when nothing is sent) and the overflow drop flag.
// Configuration (APB): tx_period at address 0, the number of frames between
// sent bytes; write it only while no words are in flight.
//
// A word passes the result stage, then the output register. Throughput is
// one word per cycle unless the receiver stalls: pointer and pacing counter
// update on acceptance; the ring memory read registers in the result stage.
// A result stage and an output register are separate, so one more word is
// taken while a result waits; with the receiver stalled, s_tready drops once
// both stages hold data, and the output word holds steady.
// Reset clears the pointers, the pacing counter and the pipeline and sets
// tx_period to 16. The ring memory needs no clearing, since only written
// entries are ever read.
module midi_byte_pacer_fifo
  import mbp_pkg::*;
#(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // tdata: port_word[31:0]
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // tdata: send_valid[0], midi_byte[8:1], overflow_drop[9], zeros[15:10]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);

  logic [7:0]       tx_period;
  logic             accept;
  logic             ram_we, ram_re;
  logic [PTR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]       ram_wdata, ram_rdata;
  issue_t           issue, stage_issue;
  logic             stage_valid, advance;
  logic [7:0]       sent_byte;

  mbp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .tx_period (tx_period)
  );

  mbp_ctrl #(.RING_DEPTH(RING_DEPTH)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .port_word (s_tdata),
    .tx_period (tx_period),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .issue     (issue)
  );

  mbp_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake: the result stage moves on whenever the output register frees.
  assign advance  = stage_valid && (!m_tvalid || m_tready);
  assign s_tready = !stage_valid || advance;
  assign accept   = s_tvalid && s_tready;

  // Result stage: holds the flags while the memory read completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_issue <= issue;
    end
  end

  // Pick the sent byte, forwarding a byte written in the same frame.
  always_comb begin
    if (!stage_issue.send) begin
      sent_byte = 8'd0;
    end else if (stage_issue.bypass) begin
      sent_byte = stage_issue.push_byte;
    end else begin
      sent_byte = ram_rdata;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {{(OUT_DATA_W-10){1'b0}}, stage_issue.drop, sent_byte, stage_issue.send};
    end
  end

endmodule

@@ src/mbp_checker.sv @@
module mbp_checker
  import mbp_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  s_tvalid,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata
);

  // A stalled result word holds its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  // No byte is reported unless a send is flagged.
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
    else $error("byte nonzero without send");

  // The pipeline is empty after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // With the output register free, the input is never blocked.
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid || m_tready |-> s_tready)
    else $error("input stalled while output can move");

endmodule

bind midi_byte_pacer_fifo mbp_checker u_mbp_checker (.*);

@@ tb/testbench.sv @@
module testbench;
  import mbp_pkg::*;

  // One result word as it leaves the block, lowest field in the lowest bit.
  typedef struct packed {
    logic [5:0] pad;
    logic       drop;
    logic [7:0] midi;
    logic       sent;
  } frame_result_t;

  // A row of the directed script: either a run of identical port words or a
  // register write made while the block is idle.
  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_ADDR_W-1:0] addr;
    logic [31:0]           value;
    logic [7:0]            reps;
    logic                  typed;
    frame_result_t         want;
  } script_row_t;

  localparam logic [CFG_ADDR_W-1:0] ADDR_TX_PERIOD = {REG_TX_PERIOD, 2'b00};
  // Address of the first slot past the only register; writes there do nothing.
  localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 3'd4;

  localparam frame_result_t NOTHING_SENT = '0;
  localparam frame_result_t SENT_A5 = '{pad: 6'd0, drop: 1'b0, midi: 8'hA5, sent: 1'b1};

  localparam int SCRIPT_ROWS = 15;
  localparam script_row_t SCRIPT [SCRIPT_ROWS] = '{
    // Reset period of 16: an empty frame, then a push that leaves at once.
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h0000_0000, 8'd1, 1'b1, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'hFF00_00A5, 8'd1, 1'b1, SENT_A5},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h01FF_FF3C, 8'd1, 1'b1, NOTHING_SENT},
    // Marker bytes on either side of 0x80, the largest marker byte, and a word that carries nothing.
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h80AB_CD00, 8'd1, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h00FF_FFFF, 8'd1, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h7F00_00FF, 8'd1, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'hFFFF_FFFF, 8'd1, 1'b0, NOTHING_SENT},
    // Zero period, then a write past the register map that must not stick.
    '{ROW_CFG,  ADDR_TX_PERIOD, 32'h0000_0000, 8'd0, 1'b0, NOTHING_SENT},
    '{ROW_CFG,  ADDR_SPARE,     32'hFFFF_FFFF, 8'd0, 1'b0, NOTHING_SENT},
    // Let the old count run out and drain the ring one byte per frame.
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h0000_0000, 8'd14, 1'b0, NOTHING_SENT},
    // Empty ring: the byte pushed in a frame goes out in that frame.
    '{ROW_WORD, ADDR_TX_PERIOD, 32'h1200_0055, 8'd1, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'hAB00_0000, 8'd1, 1'b0, NOTHING_SENT},
    // Longest period.
    '{ROW_CFG,  ADDR_TX_PERIOD, 32'hFFFF_FFFF, 8'd0, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'hFF00_0001, 8'd1, 1'b0, NOTHING_SENT},
    '{ROW_WORD, ADDR_TX_PERIOD, 32'hAA00_00FE, 8'd1, 1'b0, NOTHING_SENT}
  };

  // Random phases: period, number of words and share of words carrying a byte.
  // The long-period phase pushes nearly every frame so the ring overflows.
  localparam int PHASES = 6;
  localparam int RANDOM_PERIOD = -1;
  localparam int CALM_PHASE = 2;
  localparam int PH_PERIOD [PHASES] = '{0, 255, 1, RANDOM_PERIOD, 3, 0};
  localparam int PH_ITEMS [PHASES] = '{120, 330, 120, 150, 120, 110};
  localparam int PH_PUSH_PCT [PHASES] = '{60, 95, 50, 40, 30, 70};

  localparam int IDLE_PCT = 11;
  localparam int LIMIT_CYCLES = 100000;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  // While set, neither side idles.
  logic calm;

  frame_result_t owed_frames [$];
  int mismatches = 0;
  int cycles = 0;

  // Shadow of the block: ring, pointers, pacing counter and period.
  logic [7:0] ring_copy [RING_DEPTH_DEF];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;
  logic [7:0] hold_left = 8'd0;
  logic [7:0] tx_period_now = TX_PERIOD_RST;

  midi_byte_pacer_fifo dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #2 clk = ~clk;

  // One frame of pacing: count down, buffer the byte, then send if allowed.
  function automatic frame_result_t pace_frame(input logic [31:0] word);
    frame_result_t r;
    r = '0;
    if (hold_left != 8'd0) hold_left = hold_left - 8'd1;
    if (word[31:24] != 8'd0) begin
      ring_copy[head_idx] = word[7:0];
      head_idx = (head_idx + 1) % RING_DEPTH_DEF;
      if (head_idx == tail_idx) begin
        tail_idx = (tail_idx + 1) % RING_DEPTH_DEF;
        r.drop = 1'b1;
      end
    end
    if (head_idx != tail_idx && hold_left == 8'd0) begin
      r.sent = 1'b1;
      r.midi = ring_copy[tail_idx];
      tail_idx = (tail_idx + 1) % RING_DEPTH_DEF;
      hold_left = tx_period_now;
    end
    return r;
  endfunction

  // Offer one port word, starting and ending at a falling edge.
  task automatic send_word(input logic [31:0] w, input logic typed,
                           input frame_result_t want);
    frame_result_t got;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= w;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    got = pace_frame(w);
    owed_frames.push_back(typed ? want : got);
    @(negedge clk);
  endtask

  // Wait until every owed result has come back and the pipeline is empty.
  task automatic wait_drained();
    while (owed_frames.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Setup and access cycles of a register write.
  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[CFG_ADDR_W-1:2] == REG_TX_PERIOD) tx_period_now = data[7:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Receiver side: random stalls except in the calm phase.
  always @(negedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Compare each result word with the oldest one owed.
  always @(posedge clk) begin
    frame_result_t got;
    frame_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (owed_frames.size() == 0) begin
        $display("%0t: result word %h with none expected", $time, got);
        mismatches++;
      end else begin
        want = owed_frames.pop_front();
        if (got.sent !== want.sent || got.midi !== want.midi ||
            got.drop !== want.drop || got.pad !== want.pad) begin
          $display({"%0t: expected sent=%b byte=%h drop=%b pad=%h, ",
                    "got sent=%b byte=%h drop=%b pad=%h"},
                   $time, want.sent, want.midi, want.drop, want.pad,
                   got.sent, got.midi, got.drop, got.pad);
          mismatches++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("midi_byte_pacer_fifo: mismatch");
      $finish;
    end
  end

  initial begin
    int row;
    int ph;
    int p;
    logic [31:0] w;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    calm = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed script.
    for (row = 0; row < SCRIPT_ROWS; row++) begin
      if (SCRIPT[row].kind == ROW_CFG) begin
        s_tvalid <= 1'b0;
        wait_drained();
        cfg_write(SCRIPT[row].addr, SCRIPT[row].value);
      end else begin
        repeat (SCRIPT[row].reps)
          send_word(SCRIPT[row].value, SCRIPT[row].typed, SCRIPT[row].want);
      end
    end

    // Random phases, each under its own period.
    for (ph = 0; ph < PHASES; ph++) begin
      p = (PH_PERIOD[ph] == RANDOM_PERIOD) ? $urandom_range(2, 20) : PH_PERIOD[ph];
      s_tvalid <= 1'b0;
      wait_drained();
      cfg_write(ADDR_SPARE, $urandom);
      w = $urandom;
      w[7:0] = p[7:0];
      cfg_write(ADDR_TX_PERIOD, w);
      calm = (ph == CALM_PHASE);
      repeat (PH_ITEMS[ph]) begin
        if ($urandom_range(99) < PH_PUSH_PCT[ph])
          w = {8'($urandom_range(1, 255)), 24'($urandom)};
        else
          w = {8'h00, 24'($urandom)};
        send_word(w, 1'b0, NOTHING_SENT);
      end
    end

    s_tvalid <= 1'b0;
    calm = 1'b0;
    wait_drained();
    if (mismatches == 0) begin
      $display("midi_byte_pacer_fifo: match");
    end else begin
      $display("midi_byte_pacer_fifo: mismatch");
    end
    $finish;
  end

endmodule
